// ===== hdl/dpy_pkg.sv =====
// Shared constants, payload types and the arctangent table for the
// direction to pitch/yaw converter. No dependencies.
package dpy_pkg;

	localparam int COORD_WIDTH     = 24;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int CORDIC_STAGES   = 20;
	localparam int GUARD_BITS      = 24;
	localparam int ACC_FRAC        = 32;
	localparam int GAIN_SHIFT      = 30 - GUARD_BITS;

	// datapath, accumulator, angle and sideband widths
	localparam int DW     = COORD_WIDTH + GUARD_BITS + 8;
	localparam int ACC_W  = ACC_FRAC + 11;
	localparam int ANG_W  = ANGLE_FRAC_BITS + 9;
	localparam int SIDE_W = DW + 2;
	localparam int PW     = COORD_WIDTH + 1 + 32;

	// sideband bit positions
	localparam int SIDE_SPECIAL = SIDE_W - 1;
	localparam int SIDE_ZPOS    = SIDE_W - 2;

	// CORDIC gain 1.6467602581 in Q30
	localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;

	localparam logic signed [ACC_W-1:0] YAW_BASE = ACC_W'(64'd180 << ACC_FRAC);

	// atan(2^-i) in degrees, Q32, rounded to nearest
	localparam logic signed [ACC_W-1:0] ATAN_DEG [32] = '{
		ACC_W'(64'd193273528320), ACC_W'(64'd114096026022),
		ACC_W'(64'd60285206653),  ACC_W'(64'd30601712202),
		ACC_W'(64'd15360239180),  ACC_W'(64'd7687607525),
		ACC_W'(64'd3844741810),   ACC_W'(64'd1922488225),
		ACC_W'(64'd961258780),    ACC_W'(64'd480631223),
		ACC_W'(64'd240315841),    ACC_W'(64'd120157949),
		ACC_W'(64'd60078978),     ACC_W'(64'd30039489),
		ACC_W'(64'd15019745),     ACC_W'(64'd7509872),
		ACC_W'(64'd3754936),      ACC_W'(64'd1877468),
		ACC_W'(64'd938734),       ACC_W'(64'd469367),
		ACC_W'(64'd234684),       ACC_W'(64'd117342),
		ACC_W'(64'd58671),        ACC_W'(64'd29335),
		ACC_W'(64'd14668),        ACC_W'(64'd7334),
		ACC_W'(64'd3667),         ACC_W'(64'd1833),
		ACC_W'(64'd917),          ACC_W'(64'd458),
		ACC_W'(64'd229),          ACC_W'(64'd115)
	};

	// one CORDIC beat: vector, angle accumulator and carried sideband
	typedef struct packed {
		logic signed [DW-1:0]    x;
		logic signed [DW-1:0]    y;
		logic signed [ACC_W-1:0] acc;
		logic [SIDE_W-1:0]       side;
	} dpy_data_t;

endpackage

// ===== hdl/dpy_if.sv =====
// Valid/ready channel interfaces: direction vector in, pitch/yaw angles out.
// Depends on dpy_pkg.
interface dpy_vec_if;
	logic valid;
	logic ready;
	logic signed [dpy_pkg::COORD_WIDTH-1:0] x_coord;
	logic signed [dpy_pkg::COORD_WIDTH-1:0] y_coord;
	logic signed [dpy_pkg::COORD_WIDTH-1:0] z_coord;

	modport source (output valid, output x_coord, output y_coord, output z_coord,
		input ready);
	modport sink (input valid, input x_coord, input y_coord, input z_coord,
		output ready);
endinterface

interface dpy_ang_if;
	logic valid;
	logic ready;
	logic [dpy_pkg::ANG_W-1:0] pitch_angle;
	logic [dpy_pkg::ANG_W-1:0] yaw_angle;

	modport source (output valid, output pitch_angle, output yaw_angle, input ready);
	modport sink (input valid, input pitch_angle, input yaw_angle, output ready);
endinterface

// ===== hdl/dpy_prep.sv =====
// Front stage: scales the vector, folds x < 0 into the right half plane,
// and forms the gain-compensated -z. Depends on dpy_pkg.
module dpy_prep (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic signed [dpy_pkg::COORD_WIDTH-1:0] x_coord,
	input  logic signed [dpy_pkg::COORD_WIDTH-1:0] y_coord,
	input  logic signed [dpy_pkg::COORD_WIDTH-1:0] z_coord,
	output logic                                   valid_s1,
	output dpy_pkg::dpy_data_t                     data_s1
);

	logic signed [dpy_pkg::DW-1:0]        xs;
	logic signed [dpy_pkg::DW-1:0]        ys;
	logic signed [dpy_pkg::COORD_WIDTH:0] nz;
	logic signed [dpy_pkg::PW-1:0]        prod;
	logic signed [dpy_pkg::DW-1:0]        zk;
	logic                                 neg;
	logic                                 special;
	logic                                 zpos;
	dpy_pkg::dpy_data_t                   nxt;

	assign xs      = dpy_pkg::DW'(x_coord) <<< dpy_pkg::GUARD_BITS;
	assign ys      = dpy_pkg::DW'(y_coord) <<< dpy_pkg::GUARD_BITS;
	assign neg     = x_coord[dpy_pkg::COORD_WIDTH-1];
	assign special = (x_coord == '0) && (y_coord == '0);
	assign zpos    = !z_coord[dpy_pkg::COORD_WIDTH-1] && (z_coord != '0);

	assign nz   = -((dpy_pkg::COORD_WIDTH+1)'(z_coord));
	assign prod = nz * dpy_pkg::GAIN_Q30;
	assign zk   = dpy_pkg::DW'(prod >>> dpy_pkg::GAIN_SHIFT);

	assign nxt.x    = neg ? -xs : xs;
	assign nxt.y    = neg ? -ys : ys;
	assign nxt.acc  = neg ? dpy_pkg::YAW_BASE : '0;
	assign nxt.side = {special, zpos, zk};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== hdl/dpy_cordic_pass.sv =====
// One vectoring CORDIC pass, one register stage per iteration; drives y to
// zero and accumulates the angle. Sideband rides along. Depends on dpy_pkg.
module dpy_cordic_pass (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  dpy_pkg::dpy_data_t in_data,
	output logic               out_valid,
	output dpy_pkg::dpy_data_t out_data
);

	logic               vld_s [dpy_pkg::CORDIC_STAGES+1];
	dpy_pkg::dpy_data_t dat_s [dpy_pkg::CORDIC_STAGES+1];

	assign vld_s[0] = in_valid;
	assign dat_s[0] = in_data;

	for (genvar i = 0; i < dpy_pkg::CORDIC_STAGES; i++) begin : g_stage
		logic signed [dpy_pkg::DW-1:0] dx;
		logic signed [dpy_pkg::DW-1:0] dy;
		logic                          dir;
		dpy_pkg::dpy_data_t            nxt;

		// rotate clockwise while y >= 0
		assign dir = !dat_s[i].y[dpy_pkg::DW-1];
		assign dx  = $signed(dat_s[i].y) >>> i;
		assign dy  = $signed(dat_s[i].x) >>> i;

		assign nxt.x    = dir ? dat_s[i].x + dx : dat_s[i].x - dx;
		assign nxt.y    = dir ? dat_s[i].y - dy : dat_s[i].y + dy;
		assign nxt.acc  = dir ? dat_s[i].acc + dpy_pkg::ATAN_DEG[i]
			: dat_s[i].acc - dpy_pkg::ATAN_DEG[i];
		assign nxt.side = dat_s[i].side;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dat_s[i+1] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[dpy_pkg::CORDIC_STAGES];
	assign out_data  = dat_s[dpy_pkg::CORDIC_STAGES];

endmodule

// ===== hdl/dpy_wrap.sv =====
// Output stage: rounds both accumulators to the output grid, wraps into
// [0, 360) and applies the zero-horizontal case. Holds the output register.
// Depends on dpy_pkg.
module dpy_wrap (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  dpy_pkg::dpy_data_t              in_data,
	output logic                            out_valid_q,
	output logic [dpy_pkg::ANG_W-1:0]       pitch_q,
	output logic [dpy_pkg::ANG_W-1:0]       yaw_q
);

	localparam int RND_SHIFT = dpy_pkg::ACC_FRAC - dpy_pkg::ANGLE_FRAC_BITS;
	localparam int RW        = dpy_pkg::ACC_W + 1 - RND_SHIFT;
	localparam logic signed [dpy_pkg::ACC_W:0] RND_HALF =
		(dpy_pkg::ACC_W+1)'(64'd1 << (RND_SHIFT - 1));
	localparam logic signed [RW-1:0] FULL = RW'(64'd360 << dpy_pkg::ANGLE_FRAC_BITS);
	localparam logic [dpy_pkg::ANG_W-1:0] PITCH_UP =
		dpy_pkg::ANG_W'(64'd270 << dpy_pkg::ANGLE_FRAC_BITS);
	localparam logic [dpy_pkg::ANG_W-1:0] PITCH_DOWN =
		dpy_pkg::ANG_W'(64'd90 << dpy_pkg::ANGLE_FRAC_BITS);

	function automatic logic [dpy_pkg::ANG_W-1:0] to_angle(
		input logic signed [dpy_pkg::ACC_W-1:0] acc);
		logic signed [dpy_pkg::ACC_W:0] sum;
		logic signed [RW-1:0]           r;
		sum = (dpy_pkg::ACC_W+1)'(acc) + RND_HALF;
		r   = RW'(sum >>> RND_SHIFT);
		if (r < 0) begin
			r = r + FULL;
		end else if (r >= FULL) begin
			r = r - FULL;
		end
		return r[dpy_pkg::ANG_W-1:0];
	endfunction

	logic                             special;
	logic                             zpos;
	logic [dpy_pkg::ANG_W-1:0]        pitch_d;
	logic [dpy_pkg::ANG_W-1:0]        yaw_d;
	logic signed [dpy_pkg::ACC_W-1:0] yaw_acc;

	assign special = in_data.side[dpy_pkg::SIDE_SPECIAL];
	assign zpos    = in_data.side[dpy_pkg::SIDE_ZPOS];
	assign yaw_acc = in_data.side[dpy_pkg::ACC_W-1:0];

	always_comb begin
		if (special) begin
			pitch_d = zpos ? PITCH_UP : PITCH_DOWN;
			yaw_d   = '0;
		end else begin
			pitch_d = to_angle(in_data.acc);
			yaw_d   = to_angle(yaw_acc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_q <= pitch_d;
			yaw_q   <= yaw_d;
		end
	end

endmodule

// ===== hdl/direction_to_pitch_yaw.sv =====
// Converts a signed direction vector to yaw = atan2(y, x) and
// pitch = atan2(-z, horizontal length), both in degrees with 16 fraction
// bits in [0, 360). One vector is accepted every clock unless the output
// stalls. Each passes one front stage (scaling and the -z gain multiply), two
// chained 20-stage vectoring CORDIC pipelines (yaw, then pitch on the yaw
// pass's length), and the rounding stage that is also the output register.
// A held output stalls the whole pipeline, so vec.ready follows ang.ready
// whenever a result is waiting; bubbles are not squeezed out.
// Depends on dpy_pkg, dpy_if, dpy_prep, dpy_cordic_pass, dpy_wrap.
module direction_to_pitch_yaw (
	input  logic     clk,
	input  logic     arst_n,
	dpy_vec_if.sink  vec,
	dpy_ang_if.source ang
);

	logic               en;
	logic               prep_valid;
	dpy_pkg::dpy_data_t prep_data;
	logic               yaw_valid;
	dpy_pkg::dpy_data_t yaw_data;
	dpy_pkg::dpy_data_t pitch_in;
	logic               pitch_valid;
	dpy_pkg::dpy_data_t pitch_data;

	assign en        = !ang.valid || ang.ready;
	assign vec.ready = en;

	dpy_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vec.valid),
		.x_coord  (vec.x_coord),
		.y_coord  (vec.y_coord),
		.z_coord  (vec.z_coord),
		.valid_s1 (prep_valid),
		.data_s1  (prep_data)
	);

	dpy_cordic_pass u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prep_valid),
		.in_data   (prep_data),
		.out_valid (yaw_valid),
		.out_data  (yaw_data)
	);

	// pitch pass: gain-scaled horizontal length against gain-scaled -z;
	// the yaw angle moves into the sideband
	assign pitch_in.x    = yaw_data.x;
	assign pitch_in.y    = $signed(yaw_data.side[dpy_pkg::DW-1:0]);
	assign pitch_in.acc  = '0;
	assign pitch_in.side = {yaw_data.side[dpy_pkg::SIDE_SPECIAL],
		yaw_data.side[dpy_pkg::SIDE_ZPOS], dpy_pkg::DW'(yaw_data.acc)};

	dpy_cordic_pass u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (yaw_valid),
		.in_data   (pitch_in),
		.out_valid (pitch_valid),
		.out_data  (pitch_data)
	);

	dpy_wrap u_wrap (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (pitch_valid),
		.in_data     (pitch_data),
		.out_valid_q (ang.valid),
		.pitch_q     (ang.pitch_angle),
		.yaw_q       (ang.yaw_angle)
	);

endmodule

// ===== hdl/dpy_checker.sv =====
// Port-level checks for direction_to_pitch_yaw, attached by bind.
// Depends on dpy_pkg and the top level.
module dpy_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [dpy_pkg::ANG_W-1:0] pitch_angle,
	input logic [dpy_pkg::ANG_W-1:0] yaw_angle
);

	localparam logic [dpy_pkg::ANG_W-1:0] FULL =
		dpy_pkg::ANG_W'(64'd360 << dpy_pkg::ANGLE_FRAC_BITS);

	// angles stay inside [0, 360)
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_angle < FULL) && (yaw_angle < FULL))
		else $error("angle out of range");

	// input side stalls exactly when a result is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not track output stall");

	// held beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pitch_angle) && $stable(yaw_angle))
		else $error("held result changed");

	// a result disappears only after it was taken
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped");

endmodule

bind direction_to_pitch_yaw dpy_checker u_dpy_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (vec.ready),
	.out_valid   (ang.valid),
	.out_ready   (ang.ready),
	.pitch_angle (ang.pitch_angle),
	.yaw_angle   (ang.yaw_angle)
);
